>>> hdl/y2r_pkg.sv
// Package for the YUYV to RGB converter: pixel types, color constants,
// lane control struct and the clamp helper. No dependencies.
package y2r_pkg;

    // Number of pixel lanes: pending odd pixel, even pixel, flushed odd pixel
    localparam int LANES = 3;
    localparam int LANE_W = $clog2(LANES + 1);

    // Lane indexes
    localparam int LANE_HELD  = 0;
    localparam int LANE_EVEN  = 1;
    localparam int LANE_FLUSH = 2;

    // Color matrix constants, scaled by 256
    localparam logic signed [10:0] K_RV = 11'sd359;
    localparam logic signed [10:0] K_GU = 11'sd88;
    localparam logic signed [10:0] K_GV = 11'sd183;
    localparam logic signed [10:0] K_BU = 11'sd456;

    // Chroma offset
    localparam logic [7:0] C_MID = 8'd128;

    // Width of the intermediate sums
    localparam int SUM_W = 19;

    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        t_rgb rgb;
        logic last;
    } t_pix;

    // Control word that travels with the lane stage
    typedef struct packed {
        logic             valid;
        logic [LANES-1:0] mask;
    } t_lane_ctl;

    // Floor shift by 8 and clamp to 0..255
    function automatic logic [7:0] clamp_shift(input t_sum t);
        logic [7:0] res;
        if (t[SUM_W-1]) begin
            res = 8'd0;
        end else if (|t[SUM_W-2:16]) begin
            res = 8'hff;
        end else begin
            res = t[15:8];
        end
        return res;
    endfunction

endpackage

>>> hdl/y2r_if.sv
// Handshake channels of the converter: YUYV macropixel input and RGB
// pixel output. No dependencies.
interface y2r_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       frame_last;

    modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                    frame_last, input ready);
    modport sink   (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                    frame_last, output ready);
endinterface

interface y2r_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       pixel_last;

    modport source (output valid, red, green, blue, pixel_last, input ready);
    modport sink   (input valid, red, green, blue, pixel_last, output ready);
endinterface

>>> hdl/y2r_lane.sv
// One color conversion lane: registered products, then sum, shift, clamp.
// Depends on y2r_pkg.
module y2r_lane
    import y2r_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [7:0] i_luma,
    input  logic [7:0] i_cb,
    input  logic [7:0] i_cr,
    output t_rgb       o_rgb
);

    logic signed [7:0] du;
    logic signed [7:0] dv;
    t_sum n_ys, n_pr, n_pgu, n_pgv, n_pb;
    t_sum r_ys, r_pr, r_pgu, r_pgv, r_pb;
    t_sum sum_r, sum_g, sum_b;

    // Centered chroma: C - 128 is C with the top bit flipped
    assign du = signed'(i_cb ^ C_MID);
    assign dv = signed'(i_cr ^ C_MID);

    // Constant multiplies
    always_comb begin
        n_ys  = t_sum'({3'b000, i_luma, 8'h00});
        n_pr  = K_RV * dv;
        n_pgu = K_GU * du;
        n_pgv = K_GV * dv;
        n_pb  = K_BU * du;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ys  <= n_ys;
            r_pr  <= n_pr;
            r_pgu <= n_pgu;
            r_pgv <= n_pgv;
            r_pb  <= n_pb;
        end
    end

    // Sum and clamp
    always_comb begin
        sum_r = r_ys + r_pr;
        sum_g = r_ys - r_pgu - r_pgv;
        sum_b = r_ys + r_pb;
        o_rgb.red   = clamp_shift(sum_r);
        o_rgb.green = clamp_shift(sum_g);
        o_rgb.blue  = clamp_shift(sum_b);
    end

endmodule

>>> hdl/y2r_merge.sv
// Merge stage: packs the active lane pixels into a small buffer and sends
// them out one per cycle while ready is high. Depends on y2r_pkg, y2r_if.
module y2r_merge
    import y2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_lane_ctl   i_ctl,
    input  t_rgb        i_lane [LANES],
    output logic        o_take,
    y2r_out_if.source   o_rgb
);

    t_pix             r_buf [LANES];
    t_pix             n_buf [LANES];
    logic [LANE_W-1:0] r_cnt, n_cnt;
    t_pix             list  [LANES];
    logic [LANE_W-1:0] fill;
    logic             pop;

    // Compact the active lanes in order
    always_comb begin
        fill = '0;
        for (int i = 0; i < LANES; i++) begin
            list[i] = '0;
        end
        for (int i = 0; i < LANES; i++) begin
            if (i_ctl.mask[i]) begin
                list[fill[$clog2(LANES)-1:0]].rgb  = i_lane[i];
                list[fill[$clog2(LANES)-1:0]].last = (i == LANE_FLUSH);
                fill = fill + 1'b1;
            end
        end
    end

    assign pop    = o_rgb.valid && o_rgb.ready;
    assign o_take = i_ctl.valid &&
                    ((r_cnt == '0) || ((r_cnt == LANE_W'(1)) && pop));

    // Buffer update: load a new group or shift out the head
    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (o_take) begin
            n_buf = list;
            n_cnt = fill;
        end else if (pop) begin
            for (int i = 0; i < LANES - 1; i++) begin
                n_buf[i] = r_buf[i+1];
            end
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    assign o_rgb.valid      = (r_cnt != '0);
    assign o_rgb.red        = r_buf[0].rgb.red;
    assign o_rgb.green      = r_buf[0].rgb.green;
    assign o_rgb.blue       = r_buf[0].rgb.blue;
    assign o_rgb.pixel_last = r_buf[0].last;

endmodule

>>> hdl/yuyv_to_rgb_converter_unit.sv
// Top level of the YUYV 4:2:2 to RGB888 converter.
// Depends on y2r_pkg, y2r_if, y2r_lane and y2r_merge.
//
// Each input item is one YUYV macropixel; each output item is one RGB pixel
// in raster order. The odd pixel of a macropixel is held until the next
// macropixel arrives, because its chroma is the floored mean of both; the
// frame's last macropixel flushes it at once with its own chroma and
// pixel_last set. Three conversion lanes (held odd pixel, even pixel,
// flushed odd pixel) work in parallel and a merge buffer sends their results
// one per cycle while the output is ready; each item gives its pixels in
// turn: two in steady state, one for the first macropixel of a longer
// frame, up to three for the last. An input passes the lane product
// registers and the merge buffer before its first pixel shows. The output
// port sets the rate; the next item is taken while the previous pixels drain.
module yuyv_to_rgb_converter_unit
    import y2r_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    y2r_in_if.sink    i_yuyv,
    y2r_out_if.source o_rgb
);

    logic       acc;
    logic       take;
    t_lane_ctl  r_ctl;
    logic [7:0] r_held_luma, r_held_cb, r_held_cr;
    logic       r_held_valid;
    logic [8:0] sum_cb, sum_cr;
    t_rgb       lane_rgb [LANES];

    assign i_yuyv.ready = !r_ctl.valid || take;
    assign acc          = i_yuyv.valid && i_yuyv.ready;

    // Chroma mean for the held odd pixel
    assign sum_cb = {1'b0, r_held_cb} + {1'b0, i_yuyv.chroma_blue};
    assign sum_cr = {1'b0, r_held_cr} + {1'b0, i_yuyv.chroma_red};

    // Lanes
    y2r_lane u_lane_held (
        .i_clk  (i_clk),
        .i_en   (i_yuyv.ready),
        .i_luma (r_held_luma),
        .i_cb   (sum_cb[8:1]),
        .i_cr   (sum_cr[8:1]),
        .o_rgb  (lane_rgb[LANE_HELD])
    );

    y2r_lane u_lane_even (
        .i_clk  (i_clk),
        .i_en   (i_yuyv.ready),
        .i_luma (i_yuyv.luma_first),
        .i_cb   (i_yuyv.chroma_blue),
        .i_cr   (i_yuyv.chroma_red),
        .o_rgb  (lane_rgb[LANE_EVEN])
    );

    y2r_lane u_lane_flush (
        .i_clk  (i_clk),
        .i_en   (i_yuyv.ready),
        .i_luma (i_yuyv.luma_second),
        .i_cb   (i_yuyv.chroma_blue),
        .i_cr   (i_yuyv.chroma_red),
        .o_rgb  (lane_rgb[LANE_FLUSH])
    );

    // Lane stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_yuyv.ready) begin
            r_ctl.valid            <= acc;
            r_ctl.mask[LANE_HELD]  <= r_held_valid;
            r_ctl.mask[LANE_EVEN]  <= 1'b1;
            r_ctl.mask[LANE_FLUSH] <= i_yuyv.frame_last;
        end
    end

    // Pending odd pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_luma  <= '0;
            r_held_cb    <= '0;
            r_held_cr    <= '0;
        end else if (acc) begin
            r_held_valid <= !i_yuyv.frame_last;
            r_held_luma  <= i_yuyv.luma_second;
            r_held_cb    <= i_yuyv.chroma_blue;
            r_held_cr    <= i_yuyv.chroma_red;
        end
    end

    y2r_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl),
        .i_lane  (lane_rgb),
        .o_take  (take),
        .o_rgb   (o_rgb)
    );

`ifndef SYNTHESIS
    // Frame end leaves nothing pending
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_yuyv.frame_last |=> !r_held_valid)
        else $error("held pixel survived frame end");

    // A mid-frame item always leaves its odd pixel pending
    a_hold_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !i_yuyv.frame_last |=> r_held_valid)
        else $error("odd pixel not held");

    // A lane group waits until the merge buffer takes it
    a_group_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.valid && !take |=> r_ctl.valid)
        else $error("lane group dropped");

    // A taken group always shows a pixel next cycle
    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_rgb.valid)
        else $error("taken group produced no pixel");
`endif

endmodule

>>> tb/y2r_rgb_checker.sv
// Pixel checker for the YUYV to RGB converter: watches the macropixel and
// RGB channels, predicts every pixel and compares. Depends on y2r_pkg, y2r_if.
`timescale 1ns / 1ps

module y2r_rgb_checker
    import y2r_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    y2r_in_if    i_yuyv,
    y2r_out_if   i_rgb,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_pixel_count
);

    // Pending odd pixel, waiting for the next macropixel's chroma
    logic [7:0] pend_luma;
    logic [7:0] pend_cb;
    logic [7:0] pend_cr;
    logic       pend_valid;

    // Pixels predicted but not yet seen on the output
    t_pix expected_pixels[$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        o_pixel_count = 0;
    end

    // Floor shift by 8, then clamp to one byte
    function automatic logic [7:0] saturate_byte(input int acc);
        int scaled;
        scaled = acc >>> 8;
        if (scaled < 0) return 8'd0;
        if (scaled > 255) return 8'd255;
        return scaled[7:0];
    endfunction

    function automatic t_rgb to_rgb(input logic [7:0] y, input logic [7:0] cb,
                                    input logic [7:0] cr);
        t_rgb px;
        int   ys;
        int   du;
        int   dv;
        ys = int'(y) << 8;
        du = int'(cb) - 128;
        dv = int'(cr) - 128;
        px.red   = saturate_byte(ys + 359 * dv);
        px.green = saturate_byte(ys - 88 * du - 183 * dv);
        px.blue  = saturate_byte(ys + 456 * du);
        return px;
    endfunction

    // Queue the pixels that one accepted macropixel releases, in raster order
    task automatic predict_macropixel(input logic [7:0] y0, input logic [7:0] cb,
                                      input logic [7:0] y1, input logic [7:0] cr,
                                      input logic frame_end);
        t_pix       px;
        logic [8:0] cb_sum;
        logic [8:0] cr_sum;
        // held odd pixel takes the floored mean of both chroma pairs
        if (pend_valid) begin
            cb_sum  = pend_cb + cb;
            cr_sum  = pend_cr + cr;
            px.rgb  = to_rgb(pend_luma, cb_sum[8:1], cr_sum[8:1]);
            px.last = 1'b0;
            expected_pixels.push_back(px);
        end
        px.rgb  = to_rgb(y0, cb, cr);
        px.last = 1'b0;
        expected_pixels.push_back(px);
        // frame end flushes the odd pixel with its own chroma
        if (frame_end) begin
            px.rgb  = to_rgb(y1, cb, cr);
            px.last = 1'b1;
            expected_pixels.push_back(px);
            pend_valid = 1'b0;
        end else begin
            pend_luma  = y1;
            pend_cb    = cb;
            pend_cr    = cr;
            pend_valid = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("pixel %0d: %s expected %0d, got %0d", o_pixel_count, name, want, got);
            o_fail_count++;
        end
    endtask

    // Sample both channels on the rising edge
    always @(posedge i_clk) begin
        t_pix want;
        if (!i_rst_n) begin
            pend_luma  = 8'd0;
            pend_cb    = 8'd0;
            pend_cr    = 8'd0;
            pend_valid = 1'b0;
            expected_pixels.delete();
        end else begin
            if (i_yuyv.valid && i_yuyv.ready) begin
                predict_macropixel(i_yuyv.luma_first, i_yuyv.chroma_blue,
                                   i_yuyv.luma_second, i_yuyv.chroma_red,
                                   i_yuyv.frame_last);
            end
            if (i_rgb.valid && i_rgb.ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel %0d arrived with none expected (r=%0d g=%0d b=%0d last=%0d)",
                           o_pixel_count, i_rgb.red, i_rgb.green, i_rgb.blue,
                           i_rgb.pixel_last);
                    o_fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red", want.rgb.red, i_rgb.red);
                    check_field("green", want.rgb.green, i_rgb.green);
                    check_field("blue", want.rgb.blue, i_rgb.blue);
                    check_field("pixel_last", want.last, i_rgb.pixel_last);
                end
                o_pixel_count++;
            end
        end
        o_outstanding = expected_pixels.size();
    end

endmodule

>>> tb/yuyv_to_rgb_converter_unit_test.sv
// Testbench top for the YUYV to RGB converter: clock, reset, macropixel
// stimulus and RGB back-pressure. Depends on y2r_if, y2r_rgb_checker, DUT.
`timescale 1ns / 1ps

module yuyv_to_rgb_converter_unit_test;

    typedef enum int {RX_FULL, RX_MOSTLY, RX_HALF, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    y2r_in_if  yuyv_ch ();
    y2r_out_if rgb_ch ();

    int fail_count;
    int outstanding;
    int pixel_count;

    int items_sent;
    int frames_sent;
    int burst_left;
    bit gaps_on;
    bit long_hold_req;

    yuyv_to_rgb_converter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_yuyv  (yuyv_ch),
        .o_rgb   (rgb_ch)
    );

    y2r_rgb_checker pixel_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_yuyv        (yuyv_ch),
        .i_rgb         (rgb_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_pixel_count (pixel_count)
    );

    always #5 i_clk = ~i_clk;

    // Offer one macropixel; with gaps on, bursts end with a random idle gap
    task automatic send_macropixel(input logic [7:0] y0, input logic [7:0] cb,
                                   input logic [7:0] y1, input logic [7:0] cr,
                                   input logic frame_end);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            yuyv_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        yuyv_ch.valid       <= 1'b1;
        yuyv_ch.luma_first  <= y0;
        yuyv_ch.chroma_blue <= cb;
        yuyv_ch.luma_second <= y1;
        yuyv_ch.chroma_red  <= cr;
        yuyv_ch.frame_last  <= frame_end;
        @(posedge i_clk);
        while (!yuyv_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
        if (frame_end) frames_sent++;
        if (burst_left > 0) burst_left--;
    endtask

    // Sender pause: drop valid and wait until every predicted pixel is out
    task automatic drain_pixels();
        yuyv_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // Byte biased toward the corners and the middle of the range
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd128;
            3: return 8'($urandom_range(0, 15));
            4: return 8'($urandom_range(240, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) begin
            send_macropixel(rand_byte(), rand_byte(), rand_byte(), rand_byte(), i == len - 1);
        end
    endtask

    // RGB receiver: random stall pattern, or a long hold-off on request
    initial begin : rgb_receiver
        t_rx_mode mode;
        int       mode_left;
        int       phase;
        int       hold_cnt;
        rgb_ch.ready = 1'b0;
        mode_left    = 0;
        phase        = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                rgb_ch.ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < 250; hold_cnt++) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 4));
                    mode_left = $urandom_range(5, 40);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_FULL:     rgb_ch.ready <= 1'b1;
                    RX_MOSTLY:   rgb_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:     rgb_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   rgb_ch.ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: rgb_ch.ready <= (phase % 3 == 0);
                    default:     rgb_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    initial begin : stimulus
        int random_goal;
        int frame_idx;
        i_rst_n             = 1'b0;
        yuyv_ch.valid       = 1'b0;
        yuyv_ch.luma_first  = 8'd0;
        yuyv_ch.chroma_blue = 8'd0;
        yuyv_ch.luma_second = 8'd0;
        yuyv_ch.chroma_red  = 8'd0;
        yuyv_ch.frame_last  = 1'b0;
        items_sent    = 0;
        frames_sent   = 0;
        burst_left    = 0;
        gaps_on       = 1'b0;
        long_hold_req = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first frame after reset, chroma at both ends, odd-sum averaging
        send_macropixel(8'd0, 8'd0, 8'd255, 8'd0, 1'b0);
        send_macropixel(8'd255, 8'd255, 8'd0, 8'd255, 1'b0);
        send_macropixel(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
        send_macropixel(8'd16, 8'd240, 8'd235, 8'd16, 1'b0);
        send_macropixel(8'd235, 8'd16, 8'd81, 8'd240, 1'b1);
        // one-macropixel frames: saturation high and low
        send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        send_macropixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_macropixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b1);
        send_macropixel(8'd0, 8'd255, 8'd255, 8'd0, 1'b1);
        send_macropixel(8'd128, 8'd128, 8'd128, 8'd128, 1'b1);
        // short frames with alternating bit patterns
        send_macropixel(8'd1, 8'd254, 8'd254, 8'd1, 1'b0);
        send_macropixel(8'd254, 8'd1, 8'd1, 8'd254, 1'b1);
        send_macropixel(8'd85, 8'd170, 8'd170, 8'd85, 1'b0);
        send_macropixel(8'd170, 8'd85, 8'd85, 8'd170, 1'b0);
        send_macropixel(8'd127, 8'd129, 8'd129, 8'd127, 1'b0);
        send_macropixel(8'd129, 8'd127, 8'd127, 8'd129, 1'b1);
        drain_pixels();

        // random frames, mostly short, with bursts and pauses
        random_goal = items_sent + 90;
        frame_idx   = 0;
        while (items_sent < random_goal) begin
            if (frame_idx == 4) begin
                // long output hold-off while input keeps coming
                gaps_on       = 1'b0;
                long_hold_req = 1'b1;
                send_frame(14);
            end else begin
                gaps_on = ($urandom_range(0, 3) != 0);
                send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(8, 16)
                                                       : $urandom_range(1, 6));
            end
            if (frame_idx % 5 == 2) drain_pixels();
            frame_idx++;
        end
        drain_pixels();

        $display("Sent %0d macropixels in %0d frames; %0d RGB pixels checked.",
                 items_sent, frames_sent, pixel_count);
        $display("Covered frame starts and ends, chroma averaging, clamping and stalls.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("Timeout: %0d pixels still expected", outstanding);
        $display("Test completed with failures");
        $finish;
    end

endmodule
